FILE: rtl/cqsr_pkg.sv
// Shared types, constants and the first-hit function of the searchable circular queue.
`default_nettype none
package cqsr_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 4;
    localparam int POS_W   = 4;
    localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_DEQUEUE = 2'd1,
        REQ_SEARCH  = 2'd2,
        REQ_REMOVE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic sel;
    } cell_ctrl_t;

    function automatic logic [SLOT_W-1:0] first_hit(input logic [DEPTH-1:0] hits);
        logic [SLOT_W-1:0] pos;
        pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                pos = SLOT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/circular_queue_search_remove.sv
// Top level of the searchable queue: control, result register and the row of cells.
`default_nettype none
// The queue keeps its entries in a row of cells in logical order, the oldest in
// the first cell. Every request is taken as it comes, so busy stays low and a
// request may be issued on every clock. Its result appears on the result ports
// for one cycle, marked by strobe, in the cycle after the request beat; head_value
// and count then show the queue after that request. The receiver cannot hold a
// result off, so it must take each result beat in the cycle that strobe marks.
// A dequeue or a removal moves the later entries one cell forward in that same
// cycle, and a search compares all cells at once and picks the first hit from
// the head.
module circular_queue_search_remove (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  req_type,
    input  wire logic [cqsr_pkg::DATA_W-1:0] value_in,
    input  wire logic [cqsr_pkg::IDX_W-1:0]  index,
    output logic                             strobe,
    output logic [1:0]                       status,
    output logic [cqsr_pkg::DATA_W-1:0]      data_out,
    output logic                             found,
    output logic [cqsr_pkg::POS_W-1:0]       position,
    output logic [cqsr_pkg::DATA_W-1:0]      head_value,
    output logic [cqsr_pkg::CNT_W-1:0]       count
);
    import cqsr_pkg::*;

    logic                accept;
    req_t                req;
    logic                full;
    logic                empty;
    logic                remove_ok;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    cnt_ext;

    cell_ctrl_t          ctrl     [DEPTH];
    logic [DATA_W-1:0]   cell_q   [DEPTH];
    logic [DATA_W-1:0]   cell_sel [DEPTH];
    logic [DEPTH-1:0]    cell_match;
    logic [DEPTH-1:0]    hits;
    logic [DATA_W-1:0]   removed;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                strobe_reg;
    logic                strobe_next;
    status_t             status_reg;
    status_t             status_next;
    logic [DATA_W-1:0]   data_reg;
    logic [DATA_W-1:0]   data_next;
    logic                found_reg;
    logic                found_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign req       = req_t'(req_type);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign idx_ext   = CMP_W'(index);
    assign cnt_ext   = CMP_W'(count_reg);
    assign remove_ok = (idx_ext < cnt_ext);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_W-1:0] neighbour;

            if (i == DEPTH - 1)
            begin : g_last
                assign neighbour = cell_q[i];
            end
            else
            begin : g_mid
                assign neighbour = cell_q[i + 1];
            end

            assign ctrl[i].load  = accept && (req == REQ_ENQUEUE) && !full
                                   && (count_reg == CNT_W'(i));
            assign ctrl[i].shift = accept
                                   && (((req == REQ_DEQUEUE) && !empty)
                                   || ((req == REQ_REMOVE) && remove_ok
                                       && (CMP_W'(i) >= idx_ext)));
            assign ctrl[i].sel   = (CMP_W'(i) == idx_ext);
            assign hits[i]       = cell_match[i] && (CNT_W'(i) < count_reg);

            cqsr_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl[i]),
                .load_data  (value_in),
                .shift_data (neighbour),
                .data       (cell_q[i]),
                .sel_data   (cell_sel[i]),
                .match      (cell_match[i])
            );
        end
    endgenerate

    always_comb
    begin
        removed = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            removed = removed | cell_sel[k];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        strobe_next = accept;
        status_next = ST_OK;
        data_next   = '0;
        found_next  = 1'b0;
        pos_next    = '0;
        if (accept)
        begin
            unique case (req)
                REQ_ENQUEUE:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_DEQUEUE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        data_next  = cell_q[0];
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                REQ_SEARCH:
                begin
                    found_next = |hits;
                    pos_next   = (|hits) ? POS_W'(first_hit(hits)) : '0;
                end
                REQ_REMOVE:
                begin
                    if (!remove_ok)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        data_next  = removed;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign data_out   = data_reg;
    assign found      = found_reg;
    assign position   = pos_reg;
    assign head_value = (count_reg != '0) ? cell_q[0] : '0;
    assign count      = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds the depth");

    a_strobe_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> strobe_reg)
        else $error("request beat gave no result");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (status_reg == ST_FULL)) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("full status with room left");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && found_reg) |-> ((status_reg == ST_OK) && (count_reg != '0)))
        else $error("search hit reported on a bad status or an empty queue");

endmodule
`default_nettype wire

FILE: rtl/cqsr_cell.sv
// One queue cell: holds an entry, loads, shifts from its neighbour and compares.
`default_nettype none
module cqsr_cell (
    input  wire logic                       clk,
    input  wire cqsr_pkg::cell_ctrl_t       ctrl,
    input  wire logic [cqsr_pkg::DATA_W-1:0] load_data,
    input  wire logic [cqsr_pkg::DATA_W-1:0] shift_data,
    output logic      [cqsr_pkg::DATA_W-1:0] data,
    output logic      [cqsr_pkg::DATA_W-1:0] sel_data,
    output logic                            match
);
    import cqsr_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = shift_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = ctrl.sel ? data_reg : '0;
    assign match    = (data_reg == load_data);

endmodule
`default_nettype wire

FILE: tb/circular_queue_search_remove_tb.sv
// Self-checking testbench of the searchable circular queue with random request gaps.
`default_nettype none
module circular_queue_search_remove_tb;

    import cqsr_pkg::*;

    typedef struct {
        req_t              kind;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  idx;
    } queue_req_t;

    typedef struct {
        status_t           st;
        logic [DATA_W-1:0] data;
        logic              hit;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] head;
        logic [CNT_W-1:0]  cnt;
    } queue_resp_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic [1:0]        req_type   = REQ_ENQUEUE;
    logic [DATA_W-1:0] value_in   = '0;
    logic [IDX_W-1:0]  index      = '0;
    logic              busy;
    logic              strobe;
    logic [1:0]        status;
    logic [DATA_W-1:0] data_out;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] head_value;
    logic [CNT_W-1:0]  count;

    queue_req_t        pending_reqs[$];
    queue_resp_t       expected_resps[$];
    int                errors     = 0;

    logic [DATA_W-1:0] shadow_ring[DEPTH];
    int                shadow_head = 0;
    int                shadow_count = 0;

    queue_req_t        beat_req;
    int                idle_left  = 0;
    bit                steady     = 1'b0;

    circular_queue_search_remove u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .value_in   (value_in),
        .index      (index),
        .strobe     (strobe),
        .status     (status),
        .data_out   (data_out),
        .found      (found),
        .position   (position),
        .head_value (head_value),
        .count      (count)
    );

    always #6 clk = ~clk;

    function automatic queue_resp_t queue_apply(input queue_req_t r);
        queue_resp_t res;
        res.st   = ST_OK;
        res.data = '0;
        res.hit  = 1'b0;
        res.pos  = '0;
        case (r.kind)
            REQ_ENQUEUE:
            begin
                if (shadow_count >= DEPTH)
                begin
                    res.st = ST_FULL;
                end
                else
                begin
                    shadow_ring[(shadow_head + shadow_count) % DEPTH] = r.value;
                    shadow_count++;
                end
            end
            REQ_DEQUEUE:
            begin
                if (shadow_count == 0)
                begin
                    res.st = ST_EMPTY;
                end
                else
                begin
                    res.data = shadow_ring[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
            end
            REQ_SEARCH:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (!res.hit && shadow_ring[(shadow_head + i) % DEPTH] == r.value)
                    begin
                        res.hit = 1'b1;
                        res.pos = POS_W'(i);
                    end
                end
            end
            default:
            begin
                if (int'(r.idx) >= shadow_count)
                begin
                    res.st = ST_RANGE;
                end
                else
                begin
                    res.data = shadow_ring[(shadow_head + r.idx) % DEPTH];
                    for (int i = r.idx; i + 1 < shadow_count; i++)
                    begin
                        shadow_ring[(shadow_head + i) % DEPTH] =
                            shadow_ring[(shadow_head + i + 1) % DEPTH];
                    end
                    shadow_count--;
                end
            end
        endcase
        res.head = (shadow_count != 0) ? shadow_ring[shadow_head] : '0;
        res.cnt  = CNT_W'(shadow_count);
        return res;
    endfunction

    function automatic queue_req_t make_req(input req_t kind, input logic [DATA_W-1:0] value,
                                            input logic [IDX_W-1:0] idx);
        queue_req_t r;
        r.kind  = kind;
        r.value = value;
        r.idx   = idx;
        return r;
    endfunction

    // Directed requests first, then random traffic in fill, drain and balanced phases.
    initial
    begin
        logic [DATA_W-1:0] pool[8];
        int                phase;
        int                pick;
        req_t              kind;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  idx;

        pending_reqs.push_back(make_req(REQ_DEQUEUE, 32'h0000_0000, 4'd0));
        pending_reqs.push_back(make_req(REQ_REMOVE,  32'h0000_0000, 4'd15));
        pending_reqs.push_back(make_req(REQ_REMOVE,  32'hFFFF_FFFF, 4'd0));
        pending_reqs.push_back(make_req(REQ_SEARCH,  32'h0000_0000, 4'd0));
        pending_reqs.push_back(make_req(REQ_ENQUEUE, 32'h8000_0000, 4'd0));
        pending_reqs.push_back(make_req(REQ_ENQUEUE, 32'h7FFF_FFFF, 4'd15));
        pending_reqs.push_back(make_req(REQ_ENQUEUE, 32'h0000_0000, 4'd0));
        pending_reqs.push_back(make_req(REQ_ENQUEUE, 32'hFFFF_FFFF, 4'd0));
        pending_reqs.push_back(make_req(REQ_SEARCH,  32'h7FFF_FFFF, 4'd0));
        pending_reqs.push_back(make_req(REQ_SEARCH,  32'hFFFF_FFFF, 4'd0));
        pending_reqs.push_back(make_req(REQ_SEARCH,  32'h0001_2345, 4'd0));
        pending_reqs.push_back(make_req(REQ_REMOVE,  32'h0000_0000, 4'd4));
        pending_reqs.push_back(make_req(REQ_REMOVE,  32'h0000_0000, 4'd1));
        pending_reqs.push_back(make_req(REQ_DEQUEUE, 32'h0000_0000, 4'd0));
        for (int i = 0; i < 14; i++)
        begin
            pending_reqs.push_back(make_req(REQ_ENQUEUE, 32'hA5A5_0000 + i, 4'd0));
        end
        pending_reqs.push_back(make_req(REQ_ENQUEUE, 32'h1234_5678, 4'd0));
        pending_reqs.push_back(make_req(REQ_SEARCH,  32'hA5A5_000D, 4'd0));
        pending_reqs.push_back(make_req(REQ_REMOVE,  32'h0000_0000, 4'd15));
        pending_reqs.push_back(make_req(REQ_REMOVE,  32'h0000_0000, 4'd0));

        foreach (pool[k])
        begin
            pool[k] = $urandom;
        end
        phase = 0;
        for (int n = 0; n < 1150; n++)
        begin
            if (n % 100 == 0)
            begin
                phase = $urandom_range(0, 2);
            end
            if ($urandom_range(0, 29) == 0)
            begin
                pool[$urandom_range(0, 7)] = $urandom;
            end
            pick = $urandom_range(0, 99);
            if (phase == 0)
            begin
                kind = (pick < 55) ? REQ_ENQUEUE : (pick < 70) ? REQ_DEQUEUE :
                       (pick < 85) ? REQ_SEARCH : REQ_REMOVE;
            end
            else if (phase == 1)
            begin
                kind = (pick < 20) ? REQ_ENQUEUE : (pick < 60) ? REQ_DEQUEUE :
                       (pick < 80) ? REQ_SEARCH : REQ_REMOVE;
            end
            else
            begin
                kind = (pick < 30) ? REQ_ENQUEUE : (pick < 55) ? REQ_DEQUEUE :
                       (pick < 80) ? REQ_SEARCH : REQ_REMOVE;
            end
            value = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 7)] : $urandom;
            idx   = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 15))
                                         : IDX_W'($urandom_range(0, 3));
            pending_reqs.push_back(make_req(kind, value, idx));
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_resps.push_back(queue_apply(beat_req));
            end
            if (start && busy)
            begin
                // The beat has not been taken yet, so the request is held.
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                beat_req = pending_reqs.pop_front();
                req_type <= beat_req.kind;
                value_in <= beat_req.value;
                index    <= beat_req.idx;
                start    <= 1'b1;
                idle_left = steady ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 39) == 0)
                begin
                    steady = !steady;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        queue_resp_t exp_r;
        if (rst_n && strobe)
        begin
            if (expected_resps.size() == 0)
            begin
                $display("%0t: unexpected result beat, status %0d data %h", $time,
                         status, data_out);
                errors++;
            end
            else
            begin
                exp_r = expected_resps.pop_front();
                if (status !== exp_r.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
                    errors++;
                end
                if (data_out !== exp_r.data)
                begin
                    $display("%0t: data_out expected %h actual %h", $time, exp_r.data,
                             data_out);
                    errors++;
                end
                if (found !== exp_r.hit)
                begin
                    $display("%0t: found expected %0d actual %0d", $time, exp_r.hit, found);
                    errors++;
                end
                if (position !== exp_r.pos)
                begin
                    $display("%0t: position expected %0d actual %0d", $time, exp_r.pos,
                             position);
                    errors++;
                end
                if (head_value !== exp_r.head)
                begin
                    $display("%0t: head_value expected %h actual %h", $time, exp_r.head,
                             head_value);
                    errors++;
                end
                if (count !== exp_r.cnt)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, exp_r.cnt, count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (pending_reqs.size() != 0 || start || expected_resps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_resps.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            if (expected_resps.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived", $time,
                         expected_resps.size());
            end
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: run timed out", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
